// ===== hdl/point_segment_projection_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the point segment projection checker
// ---------------------------------------------------------------------------
`ifndef POINT_SEGMENT_PROJECTION_ASSERT_SVH
`define POINT_SEGMENT_PROJECTION_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PSP_ASSERT_IMP(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("point segment projection: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define PSP_ASSERT_NXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("point segment projection: next-cycle check failed");

`endif

// ===== hdl/psp_pkg.sv =====
// ---------------------------------------------------------------------------
// psp_pkg
// Shared constants and types of the point segment projection block.
// ---------------------------------------------------------------------------
package psp_pkg;

  localparam int COORD_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CLAMP_NONE  = 2'd0,
    CLAMP_START = 2'd1,
    CLAMP_END   = 2'd2
  } clamp_t;

endpackage

// ===== hdl/point_segment_projection.sv =====
// ---------------------------------------------------------------------------
// point_segment_projection
// Clamped projection of a 2-D point onto a line segment, fully pipelined.
// ---------------------------------------------------------------------------
// Usage:
// An item on the input channel (in_valid / in_ready) carries a point P and
// the segment ends A and B. For each accepted item exactly one item leaves
// on the output channel (out_valid / out_ready): the projection of P onto
// the segment, clamped to its ends, and a clamp code telling whether the
// answer is interior, the start A or the end B. A degenerate segment gives
// A with the start code.
// The datapath is a row of one-bit cells: COORD_WIDTH+1 square-root cells
// for the segment length, 2*COORD_WIDTH+1 division cells for the projection
// parameter, and COORD_WIDTH cells per axis for the final scaling. Each cell
// is one pipeline stage, and a new item can be accepted in every cycle
// while the skid buffer is empty.
// The output register is backed by a one-item skid buffer. When the
// receiver stalls, the pipeline moves once more into the skid buffer and
// then freezes with in_ready low until the receiver takes an item.
// Synchronous reset clears all valid flags; no item is in flight after it.
// ---------------------------------------------------------------------------
module point_segment_projection
  import psp_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] point_x,
  input  logic signed [COORD_WIDTH-1:0] point_y,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] proj_x,
  output logic signed [COORD_WIDTH-1:0] proj_y,
  output logic [1:0]                    clamp_code
);

  localparam int W      = COORD_WIDTH;
  localparam int LW     = W + 1;          // differences and the length
  localparam int PW     = 2 * LW;         // products and the squared length
  localparam int DTW    = 2 * W + 1;      // magnitude of the dot product
  localparam int SIDE_W = 4 * W + 2 * LW; // {ax, ay, bx, by, dx, dy}

  // The whole pipeline advances together unless the skid buffer is full.
  logic en;
  logic skid_v;
  assign en       = !skid_v;
  assign in_ready = en;

  // ---- Stage 0: differences -------------------------------------------------
  logic                  v0;
  logic [SIDE_W-1:0]     side0;
  logic signed [LW-1:0]  dx0, dy0, ux0, uy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx0   <= {end_x[W-1], end_x} - {start_x[W-1], start_x};
      dy0   <= {end_y[W-1], end_y} - {start_y[W-1], start_y};
      ux0   <= {point_x[W-1], point_x} - {start_x[W-1], start_x};
      uy0   <= {point_y[W-1], point_y} - {start_y[W-1], start_y};
      side0 <= {start_x, start_y, end_x, end_y,
                {end_x[W-1], end_x} - {start_x[W-1], start_x},
                {end_y[W-1], end_y} - {start_y[W-1], start_y}};
    end
  end

  // ---- Stage 1: products ---------------------------------------------------
  logic                 v1;
  logic [SIDE_W-1:0]    side1;
  logic signed [PW-1:0] mxx1, myy1, mdx1, mdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxx1  <= dx0 * dx0;
      myy1  <= dy0 * dy0;
      mdx1  <= ux0 * dx0;
      mdy1  <= uy0 * dy0;
      side1 <= side0;
    end
  end

  // ---- Stage 2: squared length and dot product magnitude -------------------
  logic signed [PW-1:0] dot1;
  logic [PW-1:0]        dabs1;
  assign dot1  = mdx1 + mdy1;
  assign dabs1 = dot1[PW-1] ? PW'(-dot1) : PW'(dot1);

  logic              v2;
  logic [SIDE_W-1:0] side2;
  logic [PW-1:0]     sq2;
  logic              neg2;
  logic [DTW-1:0]    dm2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq2   <= mxx1 + myy1;
      neg2  <= dot1[PW-1];
      dm2   <= dabs1[DTW-1:0];
      side2 <= side1;
    end
  end

  // ---- Square-root cells: segment length -----------------------------------
  logic [PW-1:0]     sq_rad  [1:LW];
  logic [LW:0]       sq_rem  [1:LW];
  logic [LW-1:0]     sq_root [1:LW];
  logic [LW:1]       sq_v;
  logic [SIDE_W-1:0] sq_side [1:LW];
  logic [LW:1]       sq_neg;
  logic [DTW-1:0]    sq_dm   [1:LW];

  for (genvar i = 0; i < LW; i++) begin : g_sq
    logic [PW-1:0] rad_in;
    logic [LW:0]   rem_in;
    logic [LW-1:0] root_in;
    if (i == 0) begin : g_head
      assign rad_in  = sq2;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_body
      assign rad_in  = sq_rad[i];
      assign rem_in  = sq_rem[i];
      assign root_in = sq_root[i];
    end
    psp_sqrt_cell #(.LW(LW)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (rad_in),
      .rem_i  (rem_in),
      .root_i (root_in),
      .rad_o  (sq_rad[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (en) begin
      sq_v <= {sq_v[LW-1:1], v2};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = LW; j > 1; j--) begin
        sq_side[j] <= sq_side[j-1];
        sq_dm[j]   <= sq_dm[j-1];
      end
      sq_side[1] <= side2;
      sq_dm[1]   <= dm2;
      sq_neg     <= {sq_neg[LW-1:1], neg2};
    end
  end

  // ---- Division cells: |dot| / length --------------------------------------
  logic [LW-1:0]     d1_rem  [1:DTW];
  logic [DTW-1:0]    d1_nq   [1:DTW];
  logic [LW-1:0]     d1_den  [1:DTW];
  logic [DTW:1]      d1_v;
  logic [SIDE_W-1:0] d1_side [1:DTW];
  logic [DTW:1]      d1_neg;

  for (genvar i = 0; i < DTW; i++) begin : g_d1
    logic [LW-1:0]  rem_in;
    logic [DTW-1:0] nq_in;
    logic [LW-1:0]  den_in;
    if (i == 0) begin : g_head
      assign rem_in = '0;
      assign nq_in  = sq_dm[LW];
      assign den_in = sq_root[LW];
    end else begin : g_body
      assign rem_in = d1_rem[i];
      assign nq_in  = d1_nq[i];
      assign den_in = d1_den[i];
    end
    psp_div_cell #(.NW(DTW), .DW(LW)) u_cell (
      .clk   (clk),
      .en    (en),
      .rem_i (rem_in),
      .nq_i  (nq_in),
      .den_i (den_in),
      .rem_o (d1_rem[i+1]),
      .nq_o  (d1_nq[i+1]),
      .den_o (d1_den[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1_v <= '0;
    end else if (en) begin
      d1_v <= {d1_v[DTW-1:1], sq_v[LW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = DTW; j > 1; j--) begin
        d1_side[j] <= d1_side[j-1];
      end
      d1_side[1] <= sq_side[LW];
      d1_neg     <= {d1_neg[DTW-1:1], sq_neg[LW]};
    end
  end

  // ---- Stage C: classify the projection parameter k ------------------------
  // A negative dot product smaller in size than the length truncates to
  // k = 0, which is an interior answer equal to A.
  logic [DTW-1:0] q1;
  logic [LW-1:0]  len1;
  logic           neg1;
  clamp_t         code1;
  assign q1   = d1_nq[DTW];
  assign len1 = d1_den[DTW];
  assign neg1 = d1_neg[DTW];

  always_comb begin
    if ((len1 == '0) || (neg1 && (q1 != '0))) begin
      code1 = CLAMP_START;
    end else if (!neg1 && (q1 > {{(DTW-LW){1'b0}}, len1})) begin
      code1 = CLAMP_END;
    end else begin
      code1 = CLAMP_NONE;
    end
  end

  logic              cv;
  clamp_t            c_code;
  logic [LW-1:0]     c_k;
  logic [LW-1:0]     c_len;
  logic [SIDE_W-1:0] c_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= d1_v[DTW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_code <= code1;
      c_k    <= neg1 ? '0 : q1[LW-1:0];
      c_len  <= len1;
      c_side <= d1_side[DTW];
    end
  end

  // ---- Stage M: |d| * k per axis -------------------------------------------
  logic signed [LW-1:0] c_dx, c_dy;
  logic [LW-1:0]        c_adx, c_ady;
  assign c_dx  = c_side[2*LW-1:LW];
  assign c_dy  = c_side[LW-1:0];
  assign c_adx = c_dx[LW-1] ? LW'(-c_dx) : LW'(c_dx);
  assign c_ady = c_dy[LW-1] ? LW'(-c_dy) : LW'(c_dy);

  logic              mv;
  clamp_t            m_code;
  logic [LW-1:0]     m_len;
  logic [SIDE_W-1:0] m_side;
  logic [W+LW-1:0]   m_px, m_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      mv <= 1'b0;
    end else if (en) begin
      mv <= cv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_px   <= c_adx[W-1:0] * c_k;
      m_py   <= c_ady[W-1:0] * c_k;
      m_code <= c_code;
      m_len  <= c_len;
      m_side <= c_side;
    end
  end

  // ---- Division cells: |d| * k / length, one row per axis ------------------
  // The product never exceeds |d| * length, so the upper bits already form
  // a partial remainder below the length and only W quotient bits remain.
  logic [LW-1:0]     ex_rem [1:W];
  logic [W-1:0]      ex_nq  [1:W];
  logic [LW-1:0]     ex_den [1:W];
  logic [LW-1:0]     ey_rem [1:W];
  logic [W-1:0]      ey_nq  [1:W];
  logic [LW-1:0]     ey_den [1:W];
  logic [W:1]        e_v;
  logic [SIDE_W-1:0] e_side [1:W];
  clamp_t            e_code [1:W];

  for (genvar i = 0; i < W; i++) begin : g_d2
    logic [LW-1:0] xrem_in, yrem_in, xden_in, yden_in;
    logic [W-1:0]  xnq_in, ynq_in;
    if (i == 0) begin : g_head
      assign xrem_in = m_px[W+LW-1:W];
      assign xnq_in  = m_px[W-1:0];
      assign xden_in = m_len;
      assign yrem_in = m_py[W+LW-1:W];
      assign ynq_in  = m_py[W-1:0];
      assign yden_in = m_len;
    end else begin : g_body
      assign xrem_in = ex_rem[i];
      assign xnq_in  = ex_nq[i];
      assign xden_in = ex_den[i];
      assign yrem_in = ey_rem[i];
      assign ynq_in  = ey_nq[i];
      assign yden_in = ey_den[i];
    end
    psp_div_cell #(.NW(W), .DW(LW)) u_cell_x (
      .clk   (clk),
      .en    (en),
      .rem_i (xrem_in),
      .nq_i  (xnq_in),
      .den_i (xden_in),
      .rem_o (ex_rem[i+1]),
      .nq_o  (ex_nq[i+1]),
      .den_o (ex_den[i+1])
    );
    psp_div_cell #(.NW(W), .DW(LW)) u_cell_y (
      .clk   (clk),
      .en    (en),
      .rem_i (yrem_in),
      .nq_i  (ynq_in),
      .den_i (yden_in),
      .rem_o (ey_rem[i+1]),
      .nq_o  (ey_nq[i+1]),
      .den_o (ey_den[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_v <= '0;
    end else if (en) begin
      e_v <= {e_v[W-1:1], mv};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = W; j > 1; j--) begin
        e_side[j] <= e_side[j-1];
        e_code[j] <= e_code[j-1];
      end
      e_side[1] <= m_side;
      e_code[1] <= m_code;
    end
  end

  // ---- Final selection -----------------------------------------------------
  logic signed [W-1:0]  f_ax, f_ay, f_bx, f_by;
  logic signed [LW-1:0] f_dx, f_dy;
  logic [LW-1:0]        off_x, off_y;
  logic [W-1:0]         res_x, res_y;
  clamp_t               res_code;

  assign {f_ax, f_ay, f_bx, f_by, f_dx, f_dy} = e_side[W];
  assign off_x    = f_dx[LW-1] ? LW'(-{1'b0, ex_nq[W]}) : {1'b0, ex_nq[W]};
  assign off_y    = f_dy[LW-1] ? LW'(-{1'b0, ey_nq[W]}) : {1'b0, ey_nq[W]};
  assign res_code = e_code[W];

  // An interior answer lies between A and B, so the sum never wraps.
  always_comb begin
    case (res_code)
      CLAMP_START: begin
        res_x = f_ax;
        res_y = f_ay;
      end
      CLAMP_END: begin
        res_x = f_bx;
        res_y = f_by;
      end
      default: begin
        res_x = f_ax + off_x[W-1:0];
        res_y = f_ay + off_y[W-1:0];
      end
    endcase
  end

  // ---- Output register with one-item skid buffer ---------------------------
  logic              deliver;
  logic              take_main;
  logic [W-1:0]      skid_x, skid_y;
  logic [1:0]        skid_code;

  assign deliver   = e_v[W] && en;
  assign take_main = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_v    <= 1'b0;
    end else if (skid_v) begin
      if (out_ready) begin
        skid_v <= 1'b0;
      end
    end else if (deliver) begin
      if (take_main) begin
        out_valid <= 1'b1;
      end else begin
        skid_v <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (out_ready) begin
        proj_x     <= skid_x;
        proj_y     <= skid_y;
        clamp_code <= skid_code;
      end
    end else if (deliver) begin
      if (take_main) begin
        proj_x     <= res_x;
        proj_y     <= res_y;
        clamp_code <= res_code;
      end else begin
        skid_x    <= res_x;
        skid_y    <= res_y;
        skid_code <= res_code;
      end
    end
  end

endmodule

// ===== hdl/psp_sqrt_cell.sv =====
// ---------------------------------------------------------------------------
// psp_sqrt_cell
// One registered step of a digit-by-digit integer square root.
// ---------------------------------------------------------------------------
module psp_sqrt_cell #(
  parameter int LW = 17
) (
  input  logic              clk,
  input  logic              en,
  input  logic [2*LW-1:0]   rad_i,
  input  logic [LW:0]       rem_i,
  input  logic [LW-1:0]     root_i,
  output logic [2*LW-1:0]   rad_o,
  output logic [LW:0]       rem_o,
  output logic [LW-1:0]     root_o
);

  localparam int RW = 2 * LW;

  logic [LW+2:0] trial;
  logic [LW+2:0] tst;
  logic [LW+2:0] diff;
  logic          fit;

  // Bring down the next two radicand bits and try the digit one.
  assign trial = {rem_i, rad_i[RW-1 -: 2]};
  assign tst   = {1'b0, root_i, 2'b01};
  assign fit   = (trial >= tst);
  assign diff  = trial - tst;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= {rad_i[RW-3:0], 2'b00};
      rem_o  <= fit ? diff[LW:0] : trial[LW:0];
      root_o <= {root_i[LW-2:0], fit};
    end
  end

endmodule

// ===== hdl/psp_div_cell.sv =====
// ---------------------------------------------------------------------------
// psp_div_cell
// One registered step of a restoring unsigned division.
// ---------------------------------------------------------------------------
module psp_div_cell #(
  parameter int NW = 33,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] nq_i,
  input  logic [DW-1:0] den_i,
  output logic [DW-1:0] rem_o,
  output logic [NW-1:0] nq_o,
  output logic [DW-1:0] den_o
);

  logic [DW:0] trial;
  logic [DW:0] diff;
  logic        fit;

  // The numerator shifts out at the top while quotient bits shift in below.
  assign trial = {rem_i, nq_i[NW-1]};
  assign fit   = (trial >= {1'b0, den_i});
  assign diff  = trial - {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= fit ? diff[DW-1:0] : trial[DW-1:0];
      nq_o  <= {nq_i[NW-2:0], fit};
      den_o <= den_i;
    end
  end

endmodule

// ===== hdl/psp_checker.sv =====
// ---------------------------------------------------------------------------
// psp_checker
// Port-level checks of the point segment projection block.
// ---------------------------------------------------------------------------
`include "point_segment_projection_assert.svh"

module psp_checker #(
  parameter int COORD_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] proj_x,
  input logic [COORD_WIDTH-1:0] proj_y,
  input logic [1:0]             clamp_code
);

  // The input side only backs up after the receiver refused an item.
  `PSP_ASSERT_IMP(a_ready_low_after_refusal, clk, rst, !in_ready, $past(out_valid && !out_ready))

  // A full skid buffer always sits behind a presented item.
  `PSP_ASSERT_IMP(a_backup_needs_output, clk, rst, !in_ready, out_valid)

  // Once the receiver takes an item, the skid buffer drains by the next cycle.
  `PSP_ASSERT_NXT(a_ready_recovers, clk, rst, !in_ready && out_ready, in_ready)

  // A refused item stays on the port unchanged.
  `PSP_ASSERT_NXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(proj_x) && $stable(proj_y) && $stable(clamp_code))

endmodule

bind point_segment_projection psp_checker #(.COORD_WIDTH(COORD_WIDTH)) u_psp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .proj_x     (proj_x),
  .proj_y     (proj_y),
  .clamp_code (clamp_code)
);
